@@ design/bmap_pkg.sv @@
// Shared types and constants for the bump map shader.
// No dependencies; bump_map_shader and bmap_out_fifo import this package.
package bmap_pkg;

  // Input item command codes.
  localparam logic CMD_LIGHT_WRITE = 1'b0;
  localparam logic CMD_PIXEL       = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_X = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LIGHT_Y = 1'b1;

  // Fixed centering offsets added to the column and the row.
  localparam int unsigned CENTER_X = 96;
  localparam int unsigned CENTER_Y = 156;

  // Field widths set by the interface.
  localparam int unsigned HEIGHT_W   = 8;
  localparam int unsigned OFFSET_W   = 9;
  localparam int unsigned LADDR_W    = 18;
  localparam int unsigned INDEX_W    = 16;

  // Depth of the result queue in front of the output port.
  localparam int unsigned OUT_FIFO_DEPTH = 4;

  // One shaded result item.
  typedef struct packed {
    logic [HEIGHT_W-1:0] shade;
    logic [INDEX_W-1:0]  pixel_index;
    logic                frame_last;
  } result_t;

endpackage

@@ design/bump_map_shader.sv @@
// Bump map shader: one item per clock while in_ready is high, throughput set by the single RAM port pair.
// A height pixel's result passes through stage 1, the registered light map read and the queue
// after the item that completes it (the pixel one line below) is accepted.
// Reset clears the position counters, the light offsets and the result queue.
// The light map and the height window keep their contents through reset.
module bump_map_shader
  import bmap_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH   = 320,
  parameter int unsigned SCREEN_HEIGHT  = 200,
  parameter int unsigned LIGHT_DIM_LOG2 = 9
) (
  input  logic                      clk,
  input  logic                      rst,
  // Input item channel.
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      cmd,
  input  logic [LADDR_W-1:0]        light_addr,
  input  logic [HEIGHT_W-1:0]       value,
  input  logic                      frame_start,
  // Result item channel.
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [HEIGHT_W-1:0]       shade,
  output logic [INDEX_W-1:0]        pixel_index,
  output logic                      frame_last,
  // Configuration write channel.
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_W-1:0]    cfg_index,
  input  logic [OFFSET_W-1:0]       cfg_data
);

  localparam int unsigned FRAME_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned CHAIN_LEN    = 2 * SCREEN_WIDTH;
  localparam int unsigned POS_W        = $clog2(FRAME_PIXELS + 1);
  localparam int unsigned COL_W        = $clog2(SCREEN_WIDTH);
  localparam int unsigned ROW_W        = $clog2(SCREEN_HEIGHT + 1);
  localparam int unsigned LA_W         = 2 * LIGHT_DIM_LOG2;
  localparam int unsigned CNT_W        = $clog2(OUT_FIFO_DEPTH + 1);
  localparam int unsigned PEND_W       = CNT_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes are always taken; the user must issue them only
  // while the block is idle, so no item in flight sees a change; it is not enforced.
  // ---------------------------------------------------------------------------
  logic [OFFSET_W-1:0] light_x;
  logic [OFFSET_W-1:0] light_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= '0;
      light_y <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LIGHT_X: light_x <= cfg_data;
        CFG_LIGHT_Y: light_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stream position. The counters track the position of the incoming pixel;
  // a frame start forces them back to zero for that same pixel. Once a frame
  // is complete, further pixels are dropped until the next frame start.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] pos;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [POS_W-1:0] eff_pos;
  logic [COL_W-1:0] eff_col;
  logic [ROW_W-1:0] eff_row;
  logic             accept;
  logic             pix_accept;
  logic             write_accept;
  logic             shift_en;
  logic             has_result;

  assign accept       = in_valid && in_ready;
  assign pix_accept   = accept && (cmd == CMD_PIXEL);
  assign write_accept = accept && (cmd == CMD_LIGHT_WRITE);

  assign eff_pos = frame_start ? '0 : pos;
  assign eff_col = frame_start ? '0 : col;
  assign eff_row = frame_start ? '0 : row;

  assign shift_en   = pix_accept && (eff_pos < POS_W'(FRAME_PIXELS));
  // The pixel two rows down completes the window of the pixel one row up.
  assign has_result = shift_en && (eff_row >= ROW_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      col <= '0;
      row <= '0;
    end else if (shift_en) begin
      pos <= eff_pos + POS_W'(1);
      if (eff_col == COL_W'(SCREEN_WIDTH - 1)) begin
        col <= '0;
        row <= eff_row + ROW_W'(1);
      end else begin
        col <= eff_col + COL_W'(1);
        row <= eff_row;
      end
    end else if (pix_accept) begin
      // A dropped pixel past the frame end still moves nothing, but a frame
      // start is always in range, so nothing else can reach this branch.
      pos <= eff_pos;
      col <= eff_col;
      row <= eff_row;
    end
  end

  // ---------------------------------------------------------------------------
  // Height window: a chain of byte cells, cell k holding the pixel k places
  // behind the newest one. Together with the incoming pixel it spans the two
  // rows plus one pixel that a vertical and a horizontal difference need.
  // ---------------------------------------------------------------------------
  logic [HEIGHT_W-1:0] tap [CHAIN_LEN];

  for (genvar k = 0; k < CHAIN_LEN; k++) begin : g_chain
    if (k == 0) begin : g_head
      bmap_cell u_cell (
        .clk   (clk),
        .shift (shift_en),
        .d     (value),
        .q     (tap[k])
      );
    end else begin : g_body
      bmap_cell u_cell (
        .clk   (clk),
        .shift (shift_en),
        .d     (tap[k-1]),
        .q     (tap[k])
      );
    end
  end

  // Differences around the center pixel, which sits one row behind the
  // incoming pixel. Both wrap modulo 256 by their width.
  logic [HEIGHT_W-1:0] hdiff;
  logic [HEIGHT_W-1:0] vdiff;

  assign hdiff = tap[SCREEN_WIDTH-2] - tap[SCREEN_WIDTH];
  assign vdiff = value - tap[CHAIN_LEN-1];

  // ---------------------------------------------------------------------------
  // Stage 1: differences and position of the center pixel, or a pending light
  // map write. Writes travel down the same pipe as reads so that a lookup
  // always sees exactly the writes that were accepted before its pixel.
  // ---------------------------------------------------------------------------
  logic                s1_wr;
  logic                s1_pix;
  logic [LA_W-1:0]     s1_waddr;
  logic [HEIGHT_W-1:0] s1_wdata;
  logic [HEIGHT_W-1:0] s1_hd;
  logic [HEIGHT_W-1:0] s1_vd;
  logic [COL_W-1:0]    s1_col;
  logic [ROW_W-1:0]    s1_row;
  logic [INDEX_W-1:0]  s1_index;
  logic                s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_wr  <= 1'b0;
      s1_pix <= 1'b0;
    end else begin
      s1_wr  <= write_accept;
      s1_pix <= has_result;
    end
  end

  always_ff @(posedge clk) begin
    s1_waddr <= LA_W'(light_addr);
    s1_wdata <= value;
    s1_hd    <= hdiff;
    s1_vd    <= vdiff;
    s1_col   <= eff_col;
    s1_row   <= eff_row - ROW_W'(1);
    s1_index <= INDEX_W'(eff_pos - POS_W'(SCREEN_WIDTH));
    s1_last  <= (eff_pos == POS_W'(FRAME_PIXELS - 1));
  end

  // Light map address. Everything is kept modulo the light map size; the
  // horizontal term is not folded to one row before the vertical one is added,
  // so a horizontal overflow carries into the row.
  logic [LA_W-1:0] dx;
  logic [LA_W-1:0] dy;
  logic [LA_W-1:0] light_raddr;

  assign dx = {{(LA_W-HEIGHT_W){s1_hd[HEIGHT_W-1]}}, s1_hd} + LA_W'(CENTER_X)
            + LA_W'(s1_col) - {{(LA_W-OFFSET_W){light_x[OFFSET_W-1]}}, light_x};
  assign dy = {{(LA_W-HEIGHT_W){s1_vd[HEIGHT_W-1]}}, s1_vd} + LA_W'(CENTER_Y)
            + LA_W'(s1_row) - {{(LA_W-OFFSET_W){light_y[OFFSET_W-1]}}, light_y};
  assign light_raddr = {dy[LIGHT_DIM_LOG2-1:0], {LIGHT_DIM_LOG2{1'b0}}} + dx;

  // ---------------------------------------------------------------------------
  // Light map. The user must write entries before they are read, which the block
  // does not enforce; with that, the memory needs no clearing.
  // ---------------------------------------------------------------------------
  logic [HEIGHT_W-1:0] light_rdata;

  bmap_ram #(
    .WIDTH (HEIGHT_W),
    .DEPTH (2 ** LA_W)
  ) u_light_ram (
    .clk   (clk),
    .we    (s1_wr),
    .waddr (s1_waddr),
    .wdata (s1_wdata),
    .re    (s1_pix),
    .raddr (light_raddr),
    .rdata (light_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: the looked-up byte arrives and the result item enters the queue.
  // ---------------------------------------------------------------------------
  logic               s2_valid;
  logic [INDEX_W-1:0] s2_index;
  logic               s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_pix;
    end
  end

  always_ff @(posedge clk) begin
    s2_index <= s1_index;
    s2_last  <= s1_last;
  end

  result_t            push_item;
  result_t            head_item;
  logic [CNT_W-1:0]   fifo_count;
  logic [PEND_W-1:0]  pending;

  assign push_item.shade       = light_rdata;
  assign push_item.pixel_index = s2_index;
  assign push_item.frame_last  = s2_last;

  bmap_out_fifo #(
    .DEPTH (OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (s2_valid),
    .push_data  (push_item),
    .pop        (out_ready),
    .head_valid (out_valid),
    .head_data  (head_item),
    .count      (fifo_count)
  );

  assign shade       = head_item.shade;
  assign pixel_index = head_item.pixel_index;
  assign frame_last  = head_item.frame_last;

  // Items are taken only while the queue has room for every result that is
  // already on its way, so the pipeline itself never has to stall.
  assign pending  = PEND_W'(fifo_count) + PEND_W'(s1_pix) + PEND_W'(s2_valid);
  assign in_ready = (pending < PEND_W'(OUT_FIFO_DEPTH));

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    pending <= PEND_W'(OUT_FIFO_DEPTH))
    else $error("result queue holds more items than it has room for");

  a_one_ram_op: assert property (@(posedge clk) disable iff (rst)
    !(s1_wr && s1_pix))
    else $error("light map read and write in the same cycle");

  a_lookup_follows: assert property (@(posedge clk) disable iff (rst)
    has_result |=> s1_pix ##1 s2_valid)
    else $error("shaded pixel lost in the lookup pipeline");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_last)
      |-> (pixel_index == INDEX_W'(FRAME_PIXELS - 1 - SCREEN_WIDTH)))
    else $error("frame end flagged on the wrong pixel");

endmodule

@@ design/bmap_cell.sv @@
// One cell of the height window: a byte register that takes its
// neighbor's byte whenever the window advances. No package dependencies.
module bmap_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

@@ design/bmap_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read.
// No package dependencies.
module bmap_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/bmap_out_fifo.sv @@
// Small result queue between the lookup pipeline and the output port.
// Depends on bmap_pkg for the result item type.
module bmap_out_fifo
  import bmap_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  result_t                    push_data,
  input  logic                       pop,
  output logic                       head_valid,
  output result_t                    head_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  result_t          slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_pop;

  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule
